// File: rtl/tsq_pkg.sv
package tsq_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_ENQ   = 2'd0,
        STAT_DEQ   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ_RD,
        ST_FILL
    } t_state;

endpackage

// File: rtl/two_stack_queue.sv
// Queue built from two stacks held in single-port-write, registered-read RAMs.
// Enqueue and the empty/full cases: result is valid in the cycle after the item is accepted.
// Dequeue from a filled outbox: the word passes the outbox RAM read register, then the result register.
// Dequeue with refill of N inbox words: one word moved per cycle.
// Only one item is in work at a time; the next is taken once the result register frees.
// Synchronous active-low reset clears both stack counts; RAM contents are not cleared.
module two_stack_queue
    import tsq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [WORD_W-1:0] o_out_value,
    output logic [1:0]               o_status
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_in_cnt, n_in_cnt;
    logic [CNT_W-1:0]    r_out_cnt, n_out_cnt;
    logic                r_mv, n_mv;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_value, n_out_value;
    t_status             r_out_status, n_out_status;

    logic                accept;
    logic                out_take;
    logic [CNT_W-1:0]    in_cnt_m1;
    logic [CNT_W-1:0]    out_cnt_m1;

    logic                in_wr_en;
    logic                in_rd_en;
    logic [WORD_W-1:0]   in_rd_data;
    logic                ob_wr_en;
    logic                ob_rd_en;
    logic [WORD_W-1:0]   ob_rd_data;

    // Take a new item only when idle and the result register frees this cycle
    assign o_in_stall = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign in_cnt_m1  = r_in_cnt - 1'b1;
    assign out_cnt_m1 = r_out_cnt - 1'b1;

    // Next state, counters, RAM strobes and result
    always_comb begin
        n_state      = r_state;
        n_in_cnt     = r_in_cnt;
        n_out_cnt    = r_out_cnt;
        n_mv         = 1'b0;
        n_out_valid  = r_out_valid && !out_take;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        in_wr_en     = 1'b0;
        in_rd_en     = 1'b0;
        ob_wr_en     = 1'b0;
        ob_rd_en     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_ENQ) begin
                        // Push onto the inbox, or drop when full
                        n_out_valid = 1'b1;
                        n_out_value = '0;
                        if (r_in_cnt == CNT_W'(STACK_DEPTH)) begin
                            n_out_status = STAT_FULL;
                        end else begin
                            in_wr_en     = 1'b1;
                            n_in_cnt     = r_in_cnt + 1'b1;
                            n_out_status = STAT_ENQ;
                        end
                    end else if (r_out_cnt != '0) begin
                        // Pop the outbox top
                        ob_rd_en  = 1'b1;
                        n_out_cnt = out_cnt_m1;
                        n_state   = ST_DEQ_RD;
                    end else if (r_in_cnt != '0) begin
                        // Start the refill with the inbox top
                        in_rd_en = 1'b1;
                        n_in_cnt = in_cnt_m1;
                        n_mv     = 1'b1;
                        n_state  = ST_FILL;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_value  = '1;
                        n_out_status = STAT_EMPTY;
                    end
                end
            end
            ST_DEQ_RD: begin
                n_out_valid  = 1'b1;
                n_out_value  = ob_rd_data;
                n_out_status = STAT_DEQ;
                n_state      = ST_IDLE;
            end
            ST_FILL: begin
                if (r_mv && (r_in_cnt == '0)) begin
                    // Oldest word ends the move: hand it out instead of storing it
                    n_out_valid  = 1'b1;
                    n_out_value  = in_rd_data;
                    n_out_status = STAT_DEQ;
                    n_state      = ST_IDLE;
                end else begin
                    if (r_mv) begin
                        ob_wr_en  = 1'b1;
                        n_out_cnt = r_out_cnt + 1'b1;
                    end
                    if (r_in_cnt != '0) begin
                        in_rd_en = 1'b1;
                        n_in_cnt = in_cnt_m1;
                        n_mv     = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_mv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_cnt    <= n_in_cnt;
            r_out_cnt   <= n_out_cnt;
            r_mv        <= n_mv;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // Inbox stack storage
    tsq_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_W)
    ) u_inbox (
        .i_clk     (i_clk),
        .i_wr_en   (in_wr_en),
        .i_wr_addr (r_in_cnt[ADDR_W-1:0]),
        .i_wr_data (i_value),
        .i_rd_en   (in_rd_en),
        .i_rd_addr (in_cnt_m1[ADDR_W-1:0]),
        .o_rd_data (in_rd_data)
    );

    // Outbox stack storage
    tsq_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_W)
    ) u_outbox (
        .i_clk     (i_clk),
        .i_wr_en   (ob_wr_en),
        .i_wr_addr (r_out_cnt[ADDR_W-1:0]),
        .i_wr_data (in_rd_data),
        .i_rd_en   (ob_rd_en),
        .i_rd_addr (out_cnt_m1[ADDR_W-1:0]),
        .o_rd_data (ob_rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_status    = r_out_status;

endmodule

// File: rtl/tsq_ram.sv
module tsq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one word, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tsq_pkg::*;

    // Expected outcome of one operation
    typedef struct packed {
        logic [WORD_W-1:0] value;
        t_status           status;
    } t_queue_result;

    // Scoreboard: mirrors both stacks and holds the results still owed
    class tsq_scoreboard;
        logic [WORD_W-1:0] inbox_words[STACK_DEPTH];
        logic [WORD_W-1:0] outbox_words[STACK_DEPTH];
        int unsigned       inbox_level;
        int unsigned       outbox_level;
        t_queue_result     pending_results[$];
        int unsigned       mismatches;

        function new();
            inbox_level  = 0;
            outbox_level = 0;
            mismatches   = 0;
        endfunction

        // Advance the mirrored stacks by one operation
        function t_queue_result predict_result(logic op, logic [WORD_W-1:0] word);
            t_queue_result res;
            res.value = '0;
            if (op == OP_ENQ) begin
                if (inbox_level >= STACK_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    inbox_words[inbox_level] = word;
                    inbox_level++;
                    res.status = STAT_ENQ;
                end
                return res;
            end
            // Move the whole inbox over only when the outbox has run dry
            if (outbox_level == 0) begin
                while (inbox_level > 0 && outbox_level < STACK_DEPTH) begin
                    inbox_level--;
                    outbox_words[outbox_level] = inbox_words[inbox_level];
                    outbox_level++;
                end
            end
            if (outbox_level == 0) begin
                res.value  = '1;
                res.status = STAT_EMPTY;
            end else begin
                outbox_level--;
                res.value  = outbox_words[outbox_level];
                res.status = STAT_DEQ;
            end
            return res;
        endfunction

        function void note_item(logic op, logic [WORD_W-1:0] word);
            pending_results.push_back(predict_result(op, word));
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [WORD_W-1:0] value, logic [1:0] status);
            t_queue_result exp;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h/%0d with nothing expected", value, status));
                return;
            end
            exp = pending_results.pop_front();
            if (status !== exp.status)
                report($sformatf("status %0d, expected %s", status, exp.status.name()));
            if (value !== exp.value)
                report($sformatf("out_value %h, expected %h", value, exp.value));
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_opcode;
    logic signed [WORD_W-1:0] i_value;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [WORD_W-1:0] o_out_value;
    logic [1:0]               o_status;

    tsq_scoreboard queue_check = new();
    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;

    two_stack_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_value (o_out_value),
        .o_status    (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check results, then record accepted items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                queue_check.check_result(o_out_value, o_status);
            if (i_in_valid && !o_in_stall)
                queue_check.note_item(i_opcode, i_value);
        end
    end

    // Bias toward boundary words
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item, return at the edge where it is taken
    task automatic send_item(logic op, logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Hold off until every owed result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (queue_check.pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Push past the inbox limit whatever its current level
    task automatic fill_inbox();
        repeat (STACK_DEPTH + 2) send_item(OP_ENQ, rand_word());
    endtask

    // Mixed traffic, enqueue share redrawn every 16 items
    task automatic run_mixed(int unsigned count);
        int unsigned enq_pct;
        enq_pct = 50;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 16 == 0)
                enq_pct = $urandom_range(85, 20);
            if ($urandom_range(99) < enq_pct)
                send_item(OP_ENQ, rand_word());
            else
                send_item(OP_DEQ, $urandom);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_opcode      <= OP_ENQ;
        i_value       <= '0;
        send_idle_pct = 9;
        recv_idle_pct = 88;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, boundary words, all-ones word, refill order
        send_item(OP_DEQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'h8000_0000);
        send_item(OP_ENQ, 32'h7FFF_FFFF);
        send_item(OP_ENQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'hFFFF_FFFF);
        send_item(OP_ENQ, 32'h0000_0001);
        send_item(OP_DEQ, 32'hFFFF_FFFF);
        send_item(OP_DEQ, 32'h0000_0000);
        send_item(OP_ENQ, 32'h1234_5678);
        send_item(OP_DEQ, $urandom);
        send_item(OP_DEQ, $urandom);
        send_item(OP_DEQ, $urandom);
        send_item(OP_DEQ, $urandom);
        send_item(OP_DEQ, $urandom);
        send_item(OP_DEQ, $urandom);
        send_item(OP_ENQ, $urandom);
        send_item(OP_DEQ, $urandom);

        // Overflow the inbox, then refill the empty outbox from the full inbox
        fill_inbox();
        send_item(OP_DEQ, $urandom);
        run_mixed(40);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 9;
        run_mixed(150);
        wait_drained();

        // Overflow the inbox while the outbox still holds words
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) send_item(OP_ENQ, rand_word());
        send_item(OP_DEQ, $urandom);
        fill_inbox();
        run_mixed(40);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (queue_check.mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
